// File: rtl/core/cpunpm_pkg.sv
// shared types, format codes and constants for the cursor pixel unpremultiply block
`default_nettype none

package cpunpm_pkg;

	// source layout codes
	localparam logic [1:0] FMT_ARGB = 2'd0;
	localparam logic [1:0] FMT_XRGB = 2'd1;
	localparam logic [1:0] FMT_ABGR = 2'd2;
	localparam logic [1:0] FMT_XBGR = 2'd3;

	localparam int unsigned CHAN_BITS = 8;
	localparam int unsigned PIXEL_BITS = 32;
	localparam int unsigned NUM_CHANS = 3;
	// one quotient bit per cell
	localparam int unsigned QUOT_BITS = CHAN_BITS;

	localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hff;
	localparam logic [PIXEL_BITS-1:0] ALPHA_MASK = 32'hff000000;
	localparam logic [PIXEL_BITS-1:0] AG_MASK = 32'hff00ff00;

	// per colour channel long-division state
	typedef struct packed {
		logic [CHAN_BITS-1:0] rem;
		logic [CHAN_BITS-1:0] low;
		logic [CHAN_BITS-1:0] quo;
		logic                 sat;
	} chan_t;

	// item travelling down the cell row
	typedef struct packed {
		logic                       pass;
		logic [PIXEL_BITS-1:0]      word;
		logic [CHAN_BITS-1:0]       alpha;
		chan_t [NUM_CHANS-1:0]      ch;
	} cell_data_t;

endpackage

`default_nettype wire

// File: rtl/core/cpunpm_front.sv
// front stage: layout swap, forced alpha and divider set-up
`default_nettype none

module cpunpm_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [1:0]                            source_format,
	input  wire logic                                  up_valid,
	input  wire logic [cpunpm_pkg::PIXEL_BITS-1:0]     pixel,
	output logic                                       up_ready,
	input  wire logic                                  down_ready,
	output logic                                       valid_q,
	output cpunpm_pkg::cell_data_t                     data_q
);

	logic [cpunpm_pkg::PIXEL_BITS-1:0] swapped;
	logic [cpunpm_pkg::PIXEL_BITS-1:0] word;
	logic [cpunpm_pkg::CHAN_BITS-1:0]  alpha;
	logic [cpunpm_pkg::CHAN_BITS-1:0]  chan [cpunpm_pkg::NUM_CHANS];
	logic [2*cpunpm_pkg::CHAN_BITS-1:0] prod [cpunpm_pkg::NUM_CHANS];
	cpunpm_pkg::cell_data_t            next;

	// red/blue swap and forced alpha
	always_comb begin
		swapped = pixel;
		if (source_format inside {cpunpm_pkg::FMT_ABGR, cpunpm_pkg::FMT_XBGR}) begin
			swapped = (pixel & cpunpm_pkg::AG_MASK) | {8'h00, pixel[7:0], 8'h00, pixel[23:16]};
		end
		word = swapped;
		if (source_format inside {cpunpm_pkg::FMT_XRGB, cpunpm_pkg::FMT_XBGR}) begin
			word = swapped | cpunpm_pkg::ALPHA_MASK;
		end
	end

	assign alpha   = word[31:24];
	assign chan[2] = word[23:16];
	assign chan[1] = word[15:8];
	assign chan[0] = word[7:0];

	// dividend c*255 as (c<<8)-c, top byte seeds the remainder
	always_comb begin
		next.pass  = (alpha == '0) || (alpha == cpunpm_pkg::CHAN_MAX);
		next.word  = word;
		next.alpha = alpha;
		for (int i = 0; i < cpunpm_pkg::NUM_CHANS; i++) begin
			prod[i] = {chan[i], 8'h00} - {8'h00, chan[i]};
			next.ch[i].rem = prod[i][15:8];
			next.ch[i].low = prod[i][7:0];
			next.ch[i].quo = '0;
			next.ch[i].sat = (chan[i] >= alpha);
		end
	end

	assign up_ready = !valid_q || down_ready;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/cpunpm_cell.sv
// divider cell: one restoring step, one quotient bit for each colour channel
`default_nettype none

module cpunpm_cell (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   up_valid,
	input  cpunpm_pkg::cell_data_t      up_data,
	output logic                        up_ready,
	input  wire logic                   down_ready,
	output logic                        valid_q,
	output cpunpm_pkg::cell_data_t      data_q
);

	logic [cpunpm_pkg::CHAN_BITS:0] trial [cpunpm_pkg::NUM_CHANS];
	logic [cpunpm_pkg::CHAN_BITS:0] diff  [cpunpm_pkg::NUM_CHANS];
	logic                           ge    [cpunpm_pkg::NUM_CHANS];
	cpunpm_pkg::cell_data_t         next;

	// shift in next dividend bit, subtract alpha when it fits
	always_comb begin
		next = up_data;
		for (int i = 0; i < cpunpm_pkg::NUM_CHANS; i++) begin
			trial[i] = {up_data.ch[i].rem, up_data.ch[i].low[cpunpm_pkg::CHAN_BITS-1]};
			diff[i]  = trial[i] - {1'b0, up_data.alpha};
			ge[i]    = (trial[i] >= {1'b0, up_data.alpha});
			next.ch[i].rem = ge[i] ? diff[i][cpunpm_pkg::CHAN_BITS-1:0]
			                       : trial[i][cpunpm_pkg::CHAN_BITS-1:0];
			next.ch[i].low = {up_data.ch[i].low[cpunpm_pkg::CHAN_BITS-2:0], 1'b0};
			next.ch[i].quo = {up_data.ch[i].quo[cpunpm_pkg::CHAN_BITS-2:0], ge[i]};
		end
	end

	assign up_ready = !valid_q || down_ready;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/cursor_pixel_unpremultiply.sv
// top level: premultiplied cursor pixel to straight-alpha ARGB8888
//
// channel | direction | handshake         | payload
// cfg     | in        | cfg_valid/ready   | cfg_data (source format, 2 bits)
// in      | in        | in_valid/stall    | pixel_in (32 bits)
// out     | out       | out_valid/stall   | pixel_out (32 bits)
//
// one pixel per cycle while out_stall is low; one front stage, a row of
// eight divider cells (one quotient bit each, all three channels) and the output register
// reset clears the source format to ARGB and empties every stage
// each stage holds its item until the next one frees, so a stalled output
// keeps accepting pixels until the row fills
// configuration writes are always taken (cfg_ready tied high)
`default_nettype none

module cursor_pixel_unpremultiply (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pixel_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      pixel_out
);

	localparam int unsigned N = cpunpm_pkg::QUOT_BITS;

	logic [1:0]             source_format_q;
	logic                   valid [N+1];
	logic                   ready [N+2];
	cpunpm_pkg::cell_data_t data  [N+1];
	logic                   out_valid_q;
	logic [31:0]            pixel_out_q;
	logic [31:0]            result;
	cpunpm_pkg::cell_data_t last;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= cpunpm_pkg::FMT_ARGB;
		end else if (cfg_valid) begin
			source_format_q <= cfg_data;
		end
	end

	// front stage
	cpunpm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_format (source_format_q),
		.up_valid      (in_valid),
		.pixel         (pixel_in),
		.up_ready      (ready[0]),
		.down_ready    (ready[1]),
		.valid_q       (valid[0]),
		.data_q        (data[0])
	);

	assign in_stall = !ready[0];

	// row of divider cells
	for (genvar k = 0; k < N; k++) begin : g_cell
		cpunpm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (valid[k]),
			.up_data    (data[k]),
			.up_ready   (ready[k+1]),
			.down_ready (ready[k+2]),
			.valid_q    (valid[k+1]),
			.data_q     (data[k+1])
		);
	end

	// result assembly with saturation
	assign last = data[N];

	always_comb begin
		if (last.pass) begin
			result = last.word;
		end else begin
			result = {last.alpha,
			          last.ch[2].sat ? cpunpm_pkg::CHAN_MAX : last.ch[2].quo,
			          last.ch[1].sat ? cpunpm_pkg::CHAN_MAX : last.ch[1].quo,
			          last.ch[0].sat ? cpunpm_pkg::CHAN_MAX : last.ch[0].quo};
		end
	end

	// output register
	assign ready[N+1] = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready[N+1]) begin
			out_valid_q <= valid[N];
		end
	end

	always_ff @(posedge clk) begin
		if (ready[N+1] && valid[N]) begin
			pixel_out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;

endmodule

`default_nettype wire
